FILE: design/ffas_pkg.sv
// Package for the first-fit aligned segment allocator.
// Holds table sizes, the segment entry type and the status codes.
// Used by the top level and by the port checker.
`default_nettype none

package ffas_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int ADDR_W       = 32;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int SUM_W        = ADDR_W + 2;
	localparam int LG_W         = 5;
	localparam int STATUS_W     = 3;

	localparam logic [ADDR_W-1:0] BANK_RESET = ADDR_W'(67108864);

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] len;
	} seg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED   = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_FULL      = 3'd2,
		ST_FREED     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

endpackage

`default_nettype wire

FILE: design/first_fit_aligned_segment_allocator_top.sv
// First-fit aligned segment allocator, top level.
// Depends on ffas_pkg; holds the segment table memory and its sequencer.
//
// Channel   Direction  Handshake                      Payload
// cmd       in         start & !busy accepts an item  operation, request_size,
//                                                     align_log2, release_offset
// result    out        done, one cycle, no backpress  status, granted_offset
// config    in         bank_size_wr_en, no wait       bank_size_wr_data
//
// Sequence: an allocate on an empty or full table or with a zero size finishes
// at once; otherwise it scans the entries (end, align, fit test on one shared
// 34-bit adder), then shifts the tail up when entries move and writes the new
// entry. A free scans the entries for the offset, then moves the tail down over
// the freed entry. The segment memory (one read, one write per cycle) sets the
// shift and scan pace.
// Reset clears the entry count and loads the default bank size; the table
// needs no clearing pass. The receiver cannot stall: done lasts one cycle, and
// busy is low in that cycle, so the next item may be taken alongside it.
`default_nettype none

module first_fit_aligned_segment_allocator_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           operation,
	input  wire logic [ffas_pkg::ADDR_W-1:0]    request_size,
	input  wire logic [ffas_pkg::LG_W-1:0]      align_log2,
	input  wire logic [ffas_pkg::ADDR_W-1:0]    release_offset,
	input  wire logic                           bank_size_wr_en,
	input  wire logic [ffas_pkg::ADDR_W-1:0]    bank_size_wr_data,
	output logic                                done,
	output logic [ffas_pkg::STATUS_W-1:0]       status,
	output logic [ffas_pkg::ADDR_W-1:0]         granted_offset
);
	import ffas_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_AFIRST = 7'b0000010,
		S_AEND   = 7'b0000100,
		S_AALIGN = 7'b0001000,
		S_ATEST  = 7'b0010000,
		S_FSCAN  = 7'b0100000,
		S_SHIFT  = 7'b1000000
	} state_t;

	// Segment table: one write and one registered read per cycle.
	seg_t mem [MAX_SEGMENTS];
	seg_t rdata_q;
	logic [IDX_W-1:0] rd_addr;
	logic mem_we;
	logic [IDX_W-1:0] mem_wa;
	seg_t mem_wd;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [ADDR_W-1:0] bank_q;

	// Request held for the whole item.
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] amask_q;
	logic [ADDR_W-1:0] offset_req_q;

	// Scan state.
	seg_t cur_q;
	seg_t nxt_q;
	logic [SUM_W-1:0] acc_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] fptr_q;

	// Shift engine: moves entries up for insert, down for removal.
	logic ins_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] n_q;
	logic pend_s1;
	logic [IDX_W-1:0] wa_s1;
	logic [IDX_W-1:0] pidx_s1;

	logic done_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0] offset_q;

	// Shared adder and its operand select.
	logic [SUM_W-1:0] opa, opb, sum;
	logic [ADDR_W-1:0] limit;
	logic last;
	logic fit;
	logic [CNT_W-1:0] idx_next;
	logic [CNT_W-1:0] pidx_ext;
	logic accept;
	logic shift_end;

	assign accept    = start && (state_q == S_IDLE);
	assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);
	assign pidx_ext  = CNT_W'(pidx_s1);
	assign last      = (idx_next == count_q);
	assign limit     = last ? bank_q : nxt_q.start;
	assign shift_end = !pend_s1 && (n_q == '0);

	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			S_AEND: begin
				opa = SUM_W'(cur_q.start);
				opb = SUM_W'(cur_q.len);
			end
			S_AALIGN: begin
				opa = acc_q;
				opb = SUM_W'(amask_q);
			end
			S_ATEST: begin
				opa = acc_q;
				opb = SUM_W'(size_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign sum = opa + opb;
	assign fit = (sum <= SUM_W'(limit));

	// Read address for the next cycle's registered read data.
	always_comb begin
		case (state_q)
			S_AEND:  rd_addr = idx_next[IDX_W-1:0];
			S_FSCAN: rd_addr = fptr_q[IDX_W-1:0];
			S_SHIFT: rd_addr = rd_q;
			default: rd_addr = '0;
		endcase
	end

	// Write port: direct grant into an empty table, or shift moves and final insert.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = rdata_q;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_ALLOC && request_size != '0
					&& count_q == '0 && request_size <= bank_q) begin
					mem_we = 1'b1;
					mem_wa = '0;
					mem_wd.start = '0;
					mem_wd.len = request_size;
				end
			end
			S_SHIFT: begin
				if (pend_s1) begin
					mem_we = 1'b1;
					mem_wa = wa_s1;
					mem_wd = rdata_q;
				end else if (n_q == '0 && ins_q) begin
					mem_we = 1'b1;
					mem_wa = pos_q;
					mem_wd.start = acc_q[ADDR_W-1:0];
					mem_wd.len = size_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			bank_q       <= BANK_RESET;
			done_q       <= 1'b0;
			status_q     <= ST_GRANTED;
			offset_q     <= '0;
			size_q       <= '0;
			amask_q      <= '0;
			offset_req_q <= '0;
			cur_q        <= '0;
			nxt_q        <= '0;
			acc_q        <= '0;
			idx_q        <= '0;
			fptr_q       <= '0;
			ins_q        <= 1'b0;
			pos_q        <= '0;
			rd_q         <= '0;
			n_q          <= '0;
			pend_s1      <= 1'b0;
			wa_s1        <= '0;
			pidx_s1      <= '0;
		end else begin
			done_q <= 1'b0;
			if (bank_size_wr_en) begin
				bank_q <= bank_size_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						size_q       <= request_size;
						amask_q      <= (ADDR_W'(1) << align_log2) - ADDR_W'(1);
						offset_req_q <= release_offset;
						idx_q        <= '0;
						fptr_q       <= '0;
						pend_s1      <= 1'b0;
						offset_q     <= '0;
						if (operation == OP_FREE) begin
							if (count_q == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_NOT_FOUND;
							end else begin
								state_q <= S_FSCAN;
							end
						end else if (request_size == '0) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_FIT;
						end else if (count_q == CNT_W'(MAX_SEGMENTS)) begin
							done_q   <= 1'b1;
							status_q <= ST_FULL;
						end else if (count_q == '0) begin
							// Empty table: grant at zero if the bank holds it.
							done_q <= 1'b1;
							if (request_size <= bank_q) begin
								status_q <= ST_GRANTED;
								count_q  <= CNT_W'(1);
							end else begin
								status_q <= ST_NO_FIT;
							end
						end else begin
							state_q <= S_AFIRST;
						end
					end
				end
				S_AFIRST: begin
					cur_q   <= rdata_q;
					state_q <= S_AEND;
				end
				S_AEND: begin
					acc_q   <= sum;
					state_q <= S_AALIGN;
				end
				S_AALIGN: begin
					acc_q   <= sum & ~SUM_W'(amask_q);
					nxt_q   <= rdata_q;
					state_q <= S_ATEST;
				end
				S_ATEST: begin
					if (fit) begin
						// Open a slot after entry idx by moving the tail up one place.
						ins_q   <= 1'b1;
						pos_q   <= idx_next[IDX_W-1:0];
						rd_q    <= IDX_W'(count_q - CNT_W'(1));
						n_q     <= count_q - idx_next;
						pend_s1 <= 1'b0;
						state_q <= S_SHIFT;
					end else if (last) begin
						done_q   <= 1'b1;
						status_q <= ST_NO_FIT;
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= nxt_q;
						idx_q   <= idx_next[IDX_W-1:0];
						state_q <= S_AEND;
					end
				end
				S_FSCAN: begin
					if (pend_s1 && rdata_q.start == offset_req_q) begin
						// Close the hole by moving the tail down one place.
						ins_q   <= 1'b0;
						rd_q    <= pidx_s1 + IDX_W'(1);
						n_q     <= count_q - pidx_ext - CNT_W'(1);
						pend_s1 <= 1'b0;
						state_q <= S_SHIFT;
					end else if (pend_s1 && pidx_ext + CNT_W'(1) == count_q) begin
						done_q   <= 1'b1;
						status_q <= ST_NOT_FOUND;
						pend_s1  <= 1'b0;
						state_q  <= S_IDLE;
					end else if (fptr_q < count_q) begin
						pend_s1 <= 1'b1;
						pidx_s1 <= fptr_q[IDX_W-1:0];
						fptr_q  <= fptr_q + CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				S_SHIFT: begin
					if (shift_end) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
						if (ins_q) begin
							count_q  <= count_q + CNT_W'(1);
							status_q <= ST_GRANTED;
							offset_q <= acc_q[ADDR_W-1:0];
						end else begin
							count_q  <= count_q - CNT_W'(1);
							status_q <= ST_FREED;
						end
					end else if (n_q != '0) begin
						pend_s1 <= 1'b1;
						wa_s1   <= ins_q ? rd_q + IDX_W'(1) : rd_q - IDX_W'(1);
						rd_q    <= ins_q ? rd_q - IDX_W'(1) : rd_q + IDX_W'(1);
						n_q     <= n_q - CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign granted_offset = offset_q;

endmodule

`default_nettype wire

FILE: design/ffas_checker.sv
// Port checker for the first-fit aligned segment allocator.
// Depends on ffas_pkg; bound to the top level below.
`default_nettype none

module ffas_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [ffas_pkg::STATUS_W-1:0] status,
	input wire logic [ffas_pkg::ADDR_W-1:0]   granted_offset
);
	import ffas_pkg::*;

	// An accepted item either finishes at once or holds the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither busy nor done");

	// The block leaves busy only by delivering a result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result is shown only while the block is free for the next item.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Only a grant carries an offset.
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_GRANTED) |-> (granted_offset == '0))
		else $error("nonzero offset without a grant");

endmodule

bind first_fit_aligned_segment_allocator_top ffas_checker u_ffas_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.granted_offset (granted_offset)
);

`default_nettype wire
